### rtl/core/sma_pkg.sv
// Package for the simple moving average block: sizes, queue item and status
// types, and the state type of the divider sequencer.
// Used by every module in rtl/core; depends on nothing.
`default_nettype none

package sma_pkg;

  // Window length and number of fraction bits of the result.
  localparam int unsigned Window       = 16;
  localparam int unsigned FractionBits = 8;

  // Fixed field widths of the ports.
  localparam int unsigned SampleW = 12;
  localparam int unsigned AvgW    = 20;
  localparam int unsigned CountW  = 5;

  // Derived sizes.
  localparam int unsigned SlotW = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned SumW  = SampleW + $clog2(Window);
  localparam int unsigned FillW = $clog2(Window + 1);
  localparam int unsigned DivdW = SumW + FractionBits;
  localparam int unsigned StepW = $clog2(DivdW + 1);

  // Widths for the saturating compares on the way out.
  localparam int unsigned AvgCmpW = (DivdW > AvgW) ? DivdW : AvgW;
  localparam int unsigned CntCmpW = (FillW > CountW) ? FillW : CountW;

  // Decoupling queue between the front and the divider.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QLevelW    = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [SumW-1:0]  sum;
    logic [FillW-1:0] count;
  } queue_item_t;

  typedef struct packed {
    logic               empty;
    logic               full;
    logic [QLevelW-1:0] level;
  } queue_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } back_state_e;

endpackage

`default_nettype wire

### rtl/core/sma_front.sv
// Front part: accepts samples, keeps the sample ring, running sum, write
// slot and fill count, and hands {sum, count} to the queue.
// Depends on sma_pkg.
`default_nettype none

module sma_front (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         accept_i,
  input  wire  [sma_pkg::SampleW-1:0] sample_i,
  output sma_pkg::queue_item_t        item_o
);
  import sma_pkg::*;

  logic [SampleW-1:0] ring_q [Window];
  logic [SlotW-1:0]   slot_q, slot_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [FillW-1:0]   fill_q, fill_d;

  always_comb begin
    // Slots not yet written hold zero, so removing them changes nothing.
    sum_d = sum_q - SumW'(ring_q[slot_q]) + SumW'(sample_i);
    if (slot_q == SlotW'(Window - 1)) begin
      slot_d = '0;
    end else begin
      slot_d = slot_q + SlotW'(1);
    end
    if (fill_q < FillW'(Window)) begin
      fill_d = fill_q + FillW'(1);
    end else begin
      fill_d = fill_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Window; i++) begin
        ring_q[i] <= '0;
      end
      slot_q <= '0;
      sum_q  <= '0;
      fill_q <= '0;
    end else if (accept_i) begin
      ring_q[slot_q] <= sample_i;
      slot_q         <= slot_d;
      sum_q          <= sum_d;
      fill_q         <= fill_d;
    end
  end

  assign item_o.sum   = sum_d;
  assign item_o.count = fill_d;

endmodule

`default_nettype wire

### rtl/core/sma_queue.sv
// Short FIFO that decouples the front from the divider.
// Depends on sma_pkg.
`default_nettype none

module sma_queue (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  sma_pkg::queue_item_t   push_item_i,
  input  wire                    pop_i,
  output sma_pkg::queue_item_t   pop_item_o,
  output sma_pkg::queue_status_t status_o
);
  import sma_pkg::*;

  queue_item_t        mem_q [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QLevelW-1:0] level_q;
  logic               do_push, do_pop;

  assign status_o.empty = (level_q == '0);
  assign status_o.full  = (level_q == QLevelW'(QueueDepth));
  assign status_o.level = level_q;

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  assign pop_item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        level_q <= level_q + QLevelW'(1);
      end else if (do_pop && !do_push) begin
        level_q <= level_q - QLevelW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/sma_back.sv
// Back part: a radix-2 restoring divider that forms sum * 2^FractionBits / n
// one quotient bit per cycle, then saturates and registers the result.
// Depends on sma_pkg.
`default_nettype none

module sma_back (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        q_empty_i,
  input  sma_pkg::queue_item_t       q_item_i,
  output logic                       q_pop_o,
  output logic                       valid_o,
  input  wire                        stall_i,
  output logic [sma_pkg::AvgW-1:0]   average_q8_o,
  output logic [sma_pkg::CountW-1:0] samples_in_window_o
);
  import sma_pkg::*;

  localparam logic [AvgCmpW-1:0] AvgMax = AvgCmpW'({AvgW{1'b1}});
  localparam logic [CntCmpW-1:0] CntMax = CntCmpW'({CountW{1'b1}});

  back_state_e      state_q, state_d;
  logic [DivdW-1:0] dvd_q;    // dividend shifts out at the top, quotient in at the bottom
  logic [FillW-1:0] rem_q;
  logic [FillW-1:0] div_q;
  logic [StepW-1:0] step_q;
  logic [FillW:0]   trial;
  logic             ge;
  logic [FillW-1:0] rem_next;
  logic             out_free;
  logic             load_out;
  logic [AvgCmpW-1:0] quo_ext;
  logic [CntCmpW-1:0] cnt_ext;

  assign trial    = {rem_q, dvd_q[DivdW-1]};
  assign ge       = (trial >= {1'b0, div_q});
  assign rem_next = ge ? FillW'(trial - {1'b0, div_q}) : FillW'(trial);

  // The output register can take a new result when it is empty or being taken.
  assign out_free = !valid_o || !stall_i;

  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        if (step_q == StepW'(1)) begin
          state_d = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (q_pop_o) begin
      step_q <= StepW'(DivdW);
    end else if (state_q == BK_DIV) begin
      step_q <= step_q - StepW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      dvd_q <= DivdW'(q_item_i.sum) << FractionBits;
      rem_q <= '0;
      div_q <= q_item_i.count;
    end else if (state_q == BK_DIV) begin
      dvd_q <= {dvd_q[DivdW-2:0], ge};
      rem_q <= rem_next;
    end
  end

  assign quo_ext = AvgCmpW'(dvd_q);
  assign cnt_ext = CntCmpW'(div_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (load_out) begin
      valid_o <= 1'b1;
    end else if (!stall_i) begin
      valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      average_q8_o        <= (quo_ext > AvgMax) ? AvgW'(AvgMax) : AvgW'(quo_ext);
      samples_in_window_o <= (cnt_ext > CntMax) ? CountW'(CntMax) : CountW'(cnt_ext);
    end
  end

endmodule

`default_nettype wire

### rtl/core/simple_moving_average_top.sv
// Simple moving average over the last 16 samples, 8 fraction bits out.
// The 24-step radix-2 divider works on one request at a time.
// The front accepts up to two more requests while the divider is busy.
// Reset (rst_ni, asynchronous, active low) clears the ring, sum, counts and
// all valid flags; no clearing pass is needed.
`default_nettype none

module simple_moving_average_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [sma_pkg::SampleW-1:0]  sample_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [sma_pkg::AvgW-1:0]     average_q8_o,
  output logic [sma_pkg::CountW-1:0]   samples_in_window_o
);
  import sma_pkg::*;

  queue_item_t   front_item, queue_item;
  queue_status_t q_status;
  logic          in_accept;
  logic          q_pop;

  assign in_stall_o = q_status.full;
  assign in_accept  = in_valid_i && !in_stall_o;

  sma_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .sample_i (sample_i),
    .item_o   (front_item)
  );

  sma_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_item_i (front_item),
    .pop_i       (q_pop),
    .pop_item_o  (queue_item),
    .status_o    (q_status)
  );

  sma_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_empty_i           (q_status.empty),
    .q_item_i            (queue_item),
    .q_pop_o             (q_pop),
    .valid_o             (out_valid_o),
    .stall_i             (out_stall_i),
    .average_q8_o        (average_q8_o),
    .samples_in_window_o (samples_in_window_o)
  );

  // An accepted request is in the queue on the next cycle.
  a_accept_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !q_status.empty)
    else $error("accepted request did not reach the queue");

  // The divider only pops when the queue holds something.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_status.empty)
    else $error("pop from an empty queue");

  // Every result averages at least one and at most a full window of samples.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (samples_in_window_o != '0) &&
                    (CntCmpW'(samples_in_window_o) <= CntCmpW'(Window)))
    else $error("result sample count out of range");

endmodule

`default_nettype wire

### verif/sma_checker.sv
`timescale 1ns / 100ps
// Checker for the moving average block: watches both channels, predicts each
// result from the accepted samples and compares it with the block's output.
// Depends on sma_pkg for field widths and window size.

module sma_checker
  import sma_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  input  wire                in_stall_i,
  input  wire  [SampleW-1:0] sample_i,
  input  wire                out_valid_i,
  input  wire                out_stall_i,
  input  wire  [AvgW-1:0]    average_q8_i,
  input  wire  [CountW-1:0]  samples_in_window_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [AvgW-1:0]   average;
    logic [CountW-1:0] count;
  } sma_result_t;

  logic [SampleW-1:0] sample_hist [Window];
  logic [SlotW-1:0]   next_slot;
  logic [SumW-1:0]    window_sum;
  logic [FillW-1:0]   fill;
  sma_result_t        pending_averages [$];
  int                 fails;

  // Exact quotient of the scaled sum, saturated to the port widths.
  function automatic sma_result_t average_of(input logic [SumW-1:0]  sum,
                                             input logic [FillW-1:0] n);
    logic [AvgCmpW-1:0] quotient;
    sma_result_t        res;
    quotient = AvgCmpW'(sum) << FractionBits;
    quotient = quotient / AvgCmpW'(n);
    if (quotient > AvgCmpW'({AvgW{1'b1}})) begin
      res.average = '1;
    end else begin
      res.average = AvgW'(quotient);
    end
    if (CntCmpW'(n) > CntCmpW'({CountW{1'b1}})) begin
      res.count = '1;
    end else begin
      res.count = CountW'(n);
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    sma_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Window; i++) sample_hist[i] = '0;
      next_slot  = '0;
      window_sum = '0;
      fill       = '0;
      fails      = 0;
      pending_averages.delete();
    end else begin
      // Results leave before this edge's request enters, so pop first.
      if (out_valid_i && !out_stall_i) begin
        if (pending_averages.size() == 0) begin
          $display("%0t: unexpected result: average_q8 %0d samples_in_window %0d",
                   $time, average_q8_i, samples_in_window_i);
          fails++;
        end else begin
          want = pending_averages.pop_front();
          if (average_q8_i !== want.average) begin
            $display("%0t: average_q8 expected %0d actual %0d",
                     $time, want.average, average_q8_i);
            fails++;
          end
          if (samples_in_window_i !== want.count) begin
            $display("%0t: samples_in_window expected %0d actual %0d",
                     $time, want.count, samples_in_window_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        // The oldest sample leaves the sum; empty slots hold zero.
        window_sum = window_sum - SumW'(sample_hist[next_slot]) + SumW'(sample_i);
        sample_hist[next_slot] = sample_i;
        next_slot = (next_slot == SlotW'(Window - 1)) ? '0 : next_slot + SlotW'(1);
        if (fill < FillW'(Window)) fill = fill + FillW'(1);
        pending_averages.push_back(average_of(window_sum, fill));
      end
    end
    fail_count_o <= fails;
    pending_o    <= pending_averages.size();
  end

endmodule

### verif/simple_moving_average_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the moving average block: drives samples, stalls the
// result side, and reports the verdict from the checker's failure count.
// Depends on sma_pkg, simple_moving_average_top and sma_checker.

module simple_moving_average_top_tb;
  import sma_pkg::*;

  localparam int DirectedItems = 22;
  localparam int RandomItems   = 700;
  localparam int HoldStart     = 120;
  localparam int HoldCycles    = 400;
  localparam int DrainCycles   = 40;
  localparam int CycleLimit    = 200000;

  typedef enum int {
    MIX_UNIFORM,
    MIX_FULL,
    MIX_ZERO,
    MIX_LOW,
    MIX_HIGH
  } sample_mix_e;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  logic [SampleW-1:0] sample    = '0;
  logic               rx_stall  = 1'b0;
  logic               hold_off  = 1'b0;
  wire                out_stall = rx_stall | hold_off;
  wire                in_stall;
  wire                out_valid;
  wire  [AvgW-1:0]    average_q8;
  wire  [CountW-1:0]  samples_in_window;
  int                 fail_count;
  int                 pending;
  int                 sent      = 0;
  int                 cycle_cnt = 0;
  logic               tx_fast   = 1'b0;
  logic               rx_fast   = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  simple_moving_average_top uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .sample_i            (sample),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .average_q8_o        (average_q8),
    .samples_in_window_o (samples_in_window)
  );

  sma_checker u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .sample_i            (sample),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .average_q8_i        (average_q8),
    .samples_in_window_i (samples_in_window),
    .fail_count_o        (fail_count),
    .pending_o           (pending)
  );

  // Offers one request after a random gap and holds it until accepted.
  task automatic send_sample(input logic [SampleW-1:0] value);
    int gap;
    gap = (tx_fast || hold_off) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    sample   <= value;
    do @(posedge clk_i); while (!(in_valid && !in_stall));
    sent++;
  endtask

  initial begin : stimulus
    int          seg_len;
    int          pick;
    sample_mix_e mix;
    logic [SampleW-1:0] value;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Startup while the ring fills, then a full window at full scale.
    send_sample('0);
    for (int i = 0; i < 16; i++) send_sample('1);
    send_sample('0);
    send_sample(12'h555);
    send_sample(12'hAAA);
    send_sample(12'h001);
    send_sample(12'h800);

    while (sent < DirectedItems + RandomItems) begin
      seg_len = $urandom_range(1, 24);
      tx_fast = ($urandom_range(0, 3) == 0);
      pick    = $urandom_range(0, 9);
      case (pick)
        6:       mix = MIX_FULL;
        7:       mix = MIX_ZERO;
        8:       mix = MIX_LOW;
        9:       mix = MIX_HIGH;
        default: mix = MIX_UNIFORM;
      endcase
      for (int k = 0; k < seg_len; k++) begin
        case (mix)
          MIX_FULL: value = '1;
          MIX_ZERO: value = '0;
          MIX_LOW:  value = SampleW'($urandom_range(0, 15));
          MIX_HIGH: value = SampleW'($urandom_range(4080, 4095));
          default:  value = SampleW'($urandom_range(0, 4095));
        endcase
        send_sample(value);
      end
    end
    in_valid <= 1'b0;

    // Let the checker count the last accepted request before waiting on it.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("simple_moving_average_top_tb passed");
    end else begin
      $display("simple_moving_average_top_tb failed");
    end
    $finish;
  end

  // Result side: random stall before each result, with stretches of none.
  initial begin : receiver
    int wait_cycles;
    forever begin
      if ($urandom_range(0, 29) == 0) rx_fast = !rx_fast;
      wait_cycles = rx_fast ? 0 : $urandom_range(0, 16);
      if (wait_cycles > 0) begin
        rx_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      rx_stall <= 1'b0;
      do @(posedge clk_i); while (!(out_valid && !out_stall));
    end
  end

  // One long hold-off on the result side so the block backs up into its input.
  initial begin : back_pressure
    while (sent < HoldStart) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("simple_moving_average_top_tb failed");
    $finish;
  end

endmodule
